@@ rtl/core/aomq_pkg.sv @@
// ----------------------------------------------------------------------------
// Address-ordered multi-queue package
// Shared sizes, codes, command and status types for the scheduler.
// ----------------------------------------------------------------------------
package aomq_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int NUM_QUEUES = 16;
    localparam int SLOT_W     = 6;
    localparam int QID_W      = 4;
    localparam int LPA_W      = 32;
    localparam int TAG_W      = 16;
    localparam int HANDLE_W   = 16;
    localparam int CNT_W      = 7;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int QIU_W      = 5;
    localparam int CAP_W      = 7;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_ENQ  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REM  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MOVE = 3'd3;

    localparam logic [1:0] REG_QIU = 2'd0;
    localparam logic [1:0] REG_CAP = 2'd1;
    localparam logic [1:0] REG_LIM = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_REJECT = 2'd1,
        ST_NONE   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_E2, S_E3, S_D2, S_D3, S_D4,
        S_R2, S_R3, S_R4, S_M2, S_M3, S_FIN
    } t_state;

    typedef enum logic [3:0] {
        U_NOP, U_LATCH, U_CHECK, U_ENQ_FIND, U_ENQ_WRITE, U_LOOKUP, U_ENCODE,
        U_DEQ_TAKE, U_REMOVE, U_UNLINK, U_PUSH_FRONT, U_FINISH
    } t_uop;

    typedef struct packed {
        t_uop    uop;
        logic    set_status;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              qv;
        logic              occ;
        logic              full;
        logic              free_any;
        logic              slot_ok;
        logic              deq_ok;
        logic              out_busy;
    } t_dp_stat;

    typedef struct packed {
        logic [QIU_W-1:0] qiu;
        logic [CAP_W-1:0] cap;
        logic             lim;
    } t_cfg;

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [SLOT_W-1:0] lowest_one(input logic [MAX_ITEMS-1:0] v);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = MAX_ITEMS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = SLOT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/aomq_in_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface aomq_in_if;
    import aomq_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [QID_W-1:0]    queue_id;
    logic [LPA_W-1:0]    lpa;
    logic [HANDLE_W-1:0] request_handle;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, kind, queue_id, lpa, request_handle, slot, input ready);
    modport sink   (input valid, kind, queue_id, lpa, request_handle, slot, output ready);
endinterface

@@ rtl/core/aomq_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface aomq_out_if;
    import aomq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [HANDLE_W-1:0] request_out;
    logic                head_ready;
    logic [CNT_W-1:0]    item_count_out;
    logic                full_res;
    logic                all_empty;

    modport source (output valid, status, slot_out, request_out, head_ready,
                    item_count_out, full_res, all_empty, input ready);
    modport sink   (input valid, status, slot_out, request_out, head_ready,
                    item_count_out, full_res, all_empty, output ready);
endinterface

@@ rtl/core/aomq_cfg.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for queue count and capacity limit.
// ----------------------------------------------------------------------------
module aomq_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [aomq_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [aomq_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [aomq_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output aomq_pkg::t_cfg                  o_cfg
);
    import aomq_pkg::*;

    logic [QIU_W-1:0] r_qiu;
    logic [CAP_W-1:0] r_cap;
    logic             r_lim;
    logic             wr;
    logic [1:0]       idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qiu <= QIU_W'(NUM_QUEUES);
            r_cap <= CAP_W'(MAX_ITEMS);
            r_lim <= 1'b1;
        end else if (wr) begin
            case (idx)
                REG_QIU: r_qiu <= pwdata[QIU_W-1:0];
                REG_CAP: r_cap <= pwdata[CAP_W-1:0];
                REG_LIM: r_lim <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_QIU: prdata = CFG_DATA_W'(r_qiu);
            REG_CAP: prdata = CFG_DATA_W'(r_cap);
            REG_LIM: prdata = CFG_DATA_W'(r_lim);
            default: prdata = '0;
        endcase
    end

    assign o_cfg = '{qiu: r_qiu, cap: r_cap, lim: r_lim};
endmodule

@@ rtl/core/aomq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences each operation through the datapath steps.
// ----------------------------------------------------------------------------
module aomq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  aomq_pkg::t_dp_stat i_stat,
    output aomq_pkg::t_cmd     o_cmd
);
    import aomq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_FIN;
                case (i_stat.kind)
                    KIND_ENQ: begin
                        if (i_stat.qv && !i_stat.full && i_stat.free_any) begin
                            n_state = S_E2;
                        end
                    end
                    KIND_DEQ: begin
                        if (i_stat.qv && i_stat.occ) begin
                            n_state = S_D2;
                        end
                    end
                    KIND_REM: begin
                        if (i_stat.slot_ok) begin
                            n_state = S_R2;
                        end
                    end
                    KIND_MOVE: begin
                        if (i_stat.qv && i_stat.slot_ok) begin
                            n_state = S_M2;
                        end
                    end
                    default: ;
                endcase
            end
            S_E2:    n_state = S_E3;
            S_E3:    n_state = S_FIN;
            S_D2:    n_state = S_D3;
            S_D3:    n_state = S_D4;
            S_D4:    n_state = S_FIN;
            S_R2:    n_state = S_R3;
            S_R3:    n_state = S_R4;
            S_R4:    n_state = S_FIN;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_FIN;
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '{uop: U_NOP, set_status: 1'b0, status: ST_DONE};
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd = '{uop: U_LATCH, set_status: 1'b1, status: ST_DONE};
                end
            end
            S_CHECK: begin
                o_cmd.uop = U_CHECK;
                case (i_stat.kind)
                    KIND_ENQ: begin
                        if (!i_stat.qv || i_stat.full || !i_stat.free_any) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_REJECT;
                        end
                    end
                    KIND_DEQ: begin
                        o_cmd.set_status = !i_stat.qv || !i_stat.occ;
                        o_cmd.status     = !i_stat.qv ? ST_REJECT : ST_NONE;
                    end
                    KIND_REM: begin
                        o_cmd.set_status = !i_stat.slot_ok;
                        o_cmd.status     = ST_NONE;
                    end
                    KIND_MOVE: begin
                        o_cmd.set_status = !i_stat.qv || !i_stat.slot_ok;
                        o_cmd.status     = !i_stat.qv ? ST_REJECT : ST_NONE;
                    end
                    default: begin
                        o_cmd.set_status = !i_stat.qv;
                        o_cmd.status     = ST_REJECT;
                    end
                endcase
            end
            S_E2:    o_cmd.uop = U_ENQ_FIND;
            S_E3:    o_cmd.uop = U_ENQ_WRITE;
            S_D2:    o_cmd.uop = U_LOOKUP;
            S_D3:    o_cmd.uop = U_ENCODE;
            S_D4: begin
                o_cmd.uop        = U_DEQ_TAKE;
                o_cmd.set_status = !i_stat.deq_ok;
                o_cmd.status     = ST_NONE;
            end
            S_R2:    o_cmd.uop = U_LOOKUP;
            S_R3:    o_cmd.uop = U_ENCODE;
            S_R4:    o_cmd.uop = U_REMOVE;
            S_M2:    o_cmd.uop = U_UNLINK;
            S_M3:    o_cmd.uop = U_PUSH_FRONT;
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd.uop = U_FINISH;
                end
            end
            default: ;
        endcase
    end
endmodule

@@ rtl/core/aomq_dp.sv @@
// ----------------------------------------------------------------------------
// Scheduler datapath
// Slot store, linked queues, address tag table and result register.
// ----------------------------------------------------------------------------
module aomq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  aomq_pkg::t_cmd                i_cmd,
    input  aomq_pkg::t_cfg                i_cfg,
    input  logic [aomq_pkg::KIND_W-1:0]   i_kind,
    input  logic [aomq_pkg::QID_W-1:0]    i_queue_id,
    input  logic [aomq_pkg::LPA_W-1:0]    i_lpa,
    input  logic [aomq_pkg::HANDLE_W-1:0] i_request_handle,
    input  logic [aomq_pkg::SLOT_W-1:0]   i_slot,
    input  logic                          i_out_ready,
    output aomq_pkg::t_dp_stat            o_stat,
    output logic                          o_out_valid,
    output logic [aomq_pkg::STATUS_W-1:0] o_status,
    output logic [aomq_pkg::SLOT_W-1:0]   o_slot_out,
    output logic [aomq_pkg::HANDLE_W-1:0] o_request_out,
    output logic                          o_head_ready,
    output logic [aomq_pkg::CNT_W-1:0]    o_item_count_out,
    output logic                          o_full_res,
    output logic                          o_all_empty
);
    import aomq_pkg::*;

    // Latched operation word.
    logic [KIND_W-1:0]   r_kind;
    logic [QID_W-1:0]    r_qid;
    logic [LPA_W-1:0]    r_lpa;
    logic [HANDLE_W-1:0] r_req;
    logic [SLOT_W-1:0]   r_sl;
    t_status             r_status;
    logic [SLOT_W-1:0]   r_slot_res;
    logic [HANDLE_W-1:0] r_req_res;

    // Control state.
    logic [MAX_ITEMS-1:0]  r_slot_valid;
    logic [MAX_ITEMS-1:0]  r_slot_locked;
    logic [MAX_ITEMS-1:0]  r_aval;
    logic [NUM_QUEUES-1:0] r_occ;
    logic [CNT_W-1:0]      r_count;
    logic                  r_out_valid;

    // Queue ends and address keys.
    logic [SLOT_W-1:0] r_head [NUM_QUEUES];
    logic [SLOT_W-1:0] r_tail [NUM_QUEUES];
    logic [LPA_W-1:0]  r_key  [MAX_ITEMS];

    // Slot and tag memories.
    logic [LPA_W-1:0]    m_addr  [MAX_ITEMS];
    logic [TAG_W-1:0]    m_tag   [MAX_ITEMS];
    logic [HANDLE_W-1:0] m_req   [MAX_ITEMS];
    logic [QID_W-1:0]    m_owner [MAX_ITEMS];
    logic [SLOT_W-1:0]   m_next  [MAX_ITEMS];
    logic [SLOT_W-1:0]   m_prev  [MAX_ITEMS];
    logic [TAG_W-1:0]    m_cur   [MAX_ITEMS];
    logic [TAG_W-1:0]    m_new   [MAX_ITEMS];

    logic [LPA_W-1:0]    rd_addr;
    logic [TAG_W-1:0]    rd_tag;
    logic [HANDLE_W-1:0] rd_req;
    logic [QID_W-1:0]    rd_owner;
    logic [SLOT_W-1:0]   rd_next;
    logic [SLOT_W-1:0]   rd_prev;
    logic [TAG_W-1:0]    rd_cur;
    logic [TAG_W-1:0]    rd_new;

    // Step scratch registers.
    logic [SLOT_W-1:0]    r_s;
    logic [SLOT_W-1:0]    r_h;
    logic [SLOT_W-1:0]    r_e;
    logic                 r_found;
    logic [MAX_ITEMS-1:0] r_match;

    logic [QID_W-1:0]     qsel;
    logic [SLOT_W-1:0]    head_q;
    logic [SLOT_W-1:0]    tail_q;
    logic                 occ_q;
    logic [LPA_W-1:0]     cam_key;
    logic [MAX_ITEMS-1:0] cam_hit;
    logic [SLOT_W-1:0]    slot_ra;
    logic [SLOT_W-1:0]    tag_ra;
    logic                 tag_re;
    logic                 qv;
    logic                 deq_ok;
    logic                 unlinking;
    logic                 at_head;
    logic                 at_tail;
    logic [TAG_W-1:0]     enq_tag;

    logic                 next_we;
    logic [SLOT_W-1:0]    next_wa;
    logic [SLOT_W-1:0]    next_wd;
    logic                 prev_we;
    logic [SLOT_W-1:0]    prev_wa;
    logic [SLOT_W-1:0]    prev_wd;
    logic                 cur_we;
    logic [TAG_W-1:0]     cur_wd;

    assign unlinking = (i_cmd.uop == U_REMOVE) || (i_cmd.uop == U_UNLINK);
    assign qsel      = unlinking ? rd_owner : r_qid;
    assign head_q    = r_head[qsel];
    assign tail_q    = r_tail[qsel];
    assign occ_q     = r_occ[qsel];
    assign at_head   = head_q == r_sl;
    assign at_tail   = tail_q == r_sl;
    assign qv        = {1'b0, r_qid} < i_cfg.qiu;
    assign deq_ok    = !r_slot_locked[r_h] && r_found && (rd_cur == rd_tag);
    assign enq_tag   = r_found ? rd_new + TAG_W'(1) : TAG_W'(1);

    // Parallel compare of every address key.
    assign cam_key = (i_cmd.uop == U_CHECK) ? r_lpa : rd_addr;
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            cam_hit[i] = r_aval[i] && (r_key[i] == cam_key);
        end
    end

    assign slot_ra = (r_kind == KIND_DEQ) ? head_q : r_sl;
    assign tag_re  = (i_cmd.uop == U_ENQ_FIND) || (i_cmd.uop == U_ENCODE);
    always_comb begin
        if (i_cmd.uop == U_ENQ_FIND) begin
            tag_ra = (|r_match) ? lowest_one(r_match) : lowest_one(~r_aval);
        end else begin
            tag_ra = lowest_one(r_match);
        end
    end

    assign o_stat = '{kind:     r_kind,
                      qv:       qv,
                      occ:      occ_q,
                      full:     i_cfg.lim && ({1'b0, r_count} >= {1'b0, i_cfg.cap}),
                      free_any: !(&r_slot_valid),
                      slot_ok:  r_slot_valid[r_sl],
                      deq_ok:   deq_ok,
                      out_busy: r_out_valid && !i_out_ready};

    // Link pointer writes for append, unlink and push to front.
    always_comb begin
        next_we = 1'b0;
        next_wa = r_sl;
        next_wd = rd_next;
        prev_we = 1'b0;
        prev_wa = r_sl;
        prev_wd = rd_prev;
        case (i_cmd.uop)
            U_ENQ_WRITE: begin
                next_we = occ_q;
                next_wa = tail_q;
                next_wd = r_s;
                prev_we = occ_q;
                prev_wa = r_s;
                prev_wd = tail_q;
            end
            U_REMOVE, U_UNLINK: begin
                next_we = !at_head;
                next_wa = rd_prev;
                next_wd = rd_next;
                prev_we = !at_tail;
                prev_wa = rd_next;
                prev_wd = rd_prev;
            end
            U_PUSH_FRONT: begin
                next_we = occ_q;
                next_wa = r_sl;
                next_wd = head_q;
                prev_we = occ_q;
                prev_wa = head_q;
                prev_wd = r_sl;
            end
            default: ;
        endcase
    end

    always_comb begin
        cur_we = 1'b0;
        cur_wd = TAG_W'(1);
        case (i_cmd.uop)
            U_ENQ_WRITE: cur_we = !r_found;
            U_REMOVE: begin
                cur_we = r_found && (rd_new != rd_cur);
                cur_wd = rd_cur + TAG_W'(1);
            end
            default: ;
        endcase
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == U_ENQ_WRITE) begin
            m_addr[r_s] <= r_lpa;
            m_tag[r_s]  <= enq_tag;
            m_req[r_s]  <= r_req;
            m_new[r_e]  <= enq_tag;
        end
        if (i_cmd.uop == U_ENQ_WRITE) begin
            m_owner[r_s] <= r_qid;
        end else if (i_cmd.uop == U_PUSH_FRONT) begin
            m_owner[r_sl] <= r_qid;
        end
        if (next_we) begin
            m_next[next_wa] <= next_wd;
        end
        if (prev_we) begin
            m_prev[prev_wa] <= prev_wd;
        end
        if (cur_we) begin
            m_cur[r_e] <= cur_wd;
        end
        if (i_cmd.uop == U_CHECK) begin
            rd_addr  <= m_addr[slot_ra];
            rd_tag   <= m_tag[slot_ra];
            rd_req   <= m_req[slot_ra];
            rd_owner <= m_owner[slot_ra];
            rd_next  <= m_next[slot_ra];
            rd_prev  <= m_prev[slot_ra];
        end
        if (tag_re) begin
            rd_cur <= m_cur[tag_ra];
            rd_new <= m_new[tag_ra];
        end
    end

    // Payload and scratch registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.uop)
            U_LATCH: begin
                r_kind     <= i_kind;
                r_qid      <= i_queue_id;
                r_lpa      <= i_lpa;
                r_req      <= i_request_handle;
                r_sl       <= i_slot;
                r_slot_res <= '0;
                r_req_res  <= '0;
            end
            U_CHECK: begin
                r_s     <= lowest_one(~r_slot_valid);
                r_h     <= slot_ra;
                r_match <= cam_hit;
            end
            U_LOOKUP: r_match <= cam_hit;
            U_ENQ_FIND, U_ENCODE: begin
                r_found <= |r_match;
                r_e     <= tag_ra;
            end
            U_ENQ_WRITE: begin
                r_key[r_e] <= r_lpa;
                r_slot_res <= r_s;
            end
            U_DEQ_TAKE: begin
                if (deq_ok) begin
                    r_slot_res <= r_h;
                    r_req_res  <= rd_req;
                end
            end
            U_REMOVE, U_UNLINK: begin
                if (!(at_head && at_tail)) begin
                    if (at_head) begin
                        r_head[qsel] <= rd_next;
                    end
                    if (at_tail) begin
                        r_tail[qsel] <= rd_prev;
                    end
                end
            end
            default: ;
        endcase
        if (i_cmd.uop == U_ENQ_WRITE) begin
            r_tail[r_qid] <= r_s;
            if (!occ_q) begin
                r_head[r_qid] <= r_s;
            end
        end else if (i_cmd.uop == U_PUSH_FRONT) begin
            r_head[r_qid] <= r_sl;
            if (!occ_q) begin
                r_tail[r_qid] <= r_sl;
            end
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.uop == U_FINISH) begin
            o_status         <= r_status;
            o_slot_out       <= r_slot_res;
            o_request_out    <= r_req_res;
            o_head_ready     <= qv && occ_q && !r_slot_locked[head_q];
            o_item_count_out <= r_count;
            o_full_res       <= i_cfg.lim && (r_count == i_cfg.cap);
            o_all_empty      <= r_count == '0;
        end
    end

    // Valid bits, counts and handshake state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid  <= '0;
            r_slot_locked <= '0;
            r_aval        <= '0;
            r_occ         <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            case (i_cmd.uop)
                U_ENQ_WRITE: begin
                    r_slot_valid[r_s]  <= 1'b1;
                    r_slot_locked[r_s] <= 1'b0;
                    r_aval[r_e]        <= 1'b1;
                    r_occ[r_qid]       <= 1'b1;
                    r_count            <= r_count + CNT_W'(1);
                end
                U_DEQ_TAKE: begin
                    if (deq_ok) begin
                        r_slot_locked[r_h] <= 1'b1;
                    end
                end
                U_REMOVE: begin
                    if (r_found && (rd_new == rd_cur)) begin
                        r_aval[r_e] <= 1'b0;
                    end
                    if (at_head && at_tail) begin
                        r_occ[qsel] <= 1'b0;
                    end
                    r_slot_valid[r_sl]  <= 1'b0;
                    r_slot_locked[r_sl] <= 1'b0;
                    if (r_count != '0) begin
                        r_count <= r_count - CNT_W'(1);
                    end
                end
                U_UNLINK: begin
                    if (at_head && at_tail) begin
                        r_occ[qsel] <= 1'b0;
                    end
                    r_slot_locked[r_sl] <= 1'b0;
                end
                U_PUSH_FRONT: r_occ[r_qid] <= 1'b1;
                default: ;
            endcase
            if (i_cmd.uop == U_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    // The item count always equals the number of occupied slots.
    a_count_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_slot_valid)))
        else $error("item count differs from occupied slots");

    // There are never more live address entries than held items.
    a_entries_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_aval) <= $countones(r_slot_valid))
        else $error("more address entries than items");

    // An enqueue leaves its slot occupied.
    a_enq_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.uop == U_ENQ_WRITE) |=> r_slot_valid[$past(r_s)])
        else $error("enqueued slot not marked valid");

    // A successful dequeue locks the head it handed out.
    a_deq_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.uop == U_DEQ_TAKE && deq_ok) |=> r_slot_locked[$past(r_h)])
        else $error("dequeued head not locked");
`endif
endmodule

@@ rtl/core/address_ordered_multi_queue.sv @@
// ----------------------------------------------------------------------------
// Address-ordered multi-queue scheduler
// Shared slot store with per-queue linked lists and per-address ordering tags.
// ----------------------------------------------------------------------------
// Each accepted word passes the check state, then E2-E3 for enqueue, M2-M3
// for move, R2-R4 for remove or D2-D4 for dequeue (none for query and
// rejected words), then the finish state, which waits while the result side
// stalls. Words go one at a time: the next is accepted only back in idle.
// Reset: synchronous active low; clears valid, lock and occupancy bits and the
// item count at once, with no clearing pass.
module address_ordered_multi_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    aomq_in_if.sink                         i_req,
    aomq_out_if.source                      o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [aomq_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [aomq_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [aomq_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import aomq_pkg::*;

    t_cfg     cfg;
    t_cmd     cmd;
    t_dp_stat stat;
    logic     in_ready;

    assign i_req.ready = in_ready;

    aomq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    aomq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    aomq_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg            (cfg),
        .i_kind           (i_req.kind),
        .i_queue_id       (i_req.queue_id),
        .i_lpa            (i_req.lpa),
        .i_request_handle (i_req.request_handle),
        .i_slot           (i_req.slot),
        .i_out_ready      (o_rsp.ready),
        .o_stat           (stat),
        .o_out_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_slot_out       (o_rsp.slot_out),
        .o_request_out    (o_rsp.request_out),
        .o_head_ready     (o_rsp.head_ready),
        .o_item_count_out (o_rsp.item_count_out),
        .o_full_res       (o_rsp.full_res),
        .o_all_empty      (o_rsp.all_empty)
    );
endmodule

@@ sim/address_ordered_multi_queue_tb.sv @@
// ----------------------------------------------------------------------------
// Address-ordered multi-queue scheduler testbench
// Sends enqueue, dequeue, remove, move and query words with random handshake
// gaps, predicts every result word with its own model of the slot store,
// queue lists and address tag table, and checks the results in order.
// ----------------------------------------------------------------------------
import aomq_pkg::*;

typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [HANDLE_W-1:0] request_out;
    logic                head_ready;
    logic [CNT_W-1:0]    item_count_out;
    logic                full_res;
    logic                all_empty;
} t_result;

class aomq_scoreboard;
    logic [QIU_W-1:0] qiu;
    logic [CAP_W-1:0] cap;
    logic             lim;
    bit                  s_valid [MAX_ITEMS];
    bit                  s_locked[MAX_ITEMS];
    logic [LPA_W-1:0]    s_addr  [MAX_ITEMS];
    logic [TAG_W-1:0]    s_tag   [MAX_ITEMS];
    logic [HANDLE_W-1:0] s_req   [MAX_ITEMS];
    logic [QID_W-1:0]    s_owner [MAX_ITEMS];
    logic [SLOT_W-1:0]   s_next  [MAX_ITEMS];
    logic [SLOT_W-1:0]   s_prev  [MAX_ITEMS];
    logic [SLOT_W-1:0]   q_head  [NUM_QUEUES];
    logic [SLOT_W-1:0]   q_tail  [NUM_QUEUES];
    bit                  q_occ   [NUM_QUEUES];
    bit                  a_valid [MAX_ITEMS];
    logic [LPA_W-1:0]    a_key   [MAX_ITEMS];
    logic [TAG_W-1:0]    a_cur   [MAX_ITEMS];
    logic [TAG_W-1:0]    a_new   [MAX_ITEMS];
    int                  count;
    t_result             pending[$];
    int                  errors;
    int                  checked;

    function new();
        qiu = QIU_W'(NUM_QUEUES); cap = CAP_W'(MAX_ITEMS); lim = 1'b1;
        count = 0; errors = 0; checked = 0;
        for (int i = 0; i < MAX_ITEMS; i++) begin
            s_valid[i] = 0; s_locked[i] = 0; a_valid[i] = 0;
        end
        for (int i = 0; i < NUM_QUEUES; i++) q_occ[i] = 0;
    endfunction

    function int find_addr(logic [LPA_W-1:0] key);
        for (int i = 0; i < MAX_ITEMS; i++)
            if (a_valid[i] && a_key[i] == key) return i;
        return -1;
    endfunction

    function void unlink(int s);
        int q;
        bit h, t;
        q = s_owner[s];
        h = (q_head[q] == s);
        t = (q_tail[q] == s);
        if (h && t) begin
            q_occ[q] = 0;
            return;
        end
        if (h) q_head[q] = s_next[s];
        else s_next[s_prev[s]] = s_next[s];
        if (t) q_tail[q] = s_prev[s];
        else s_prev[s_next[s]] = s_prev[s];
    endfunction

    function void push(int q, int s, bit front);
        s_owner[s] = QID_W'(q);
        if (!q_occ[q]) begin
            q_head[q] = SLOT_W'(s); q_tail[q] = SLOT_W'(s); q_occ[q] = 1;
        end else if (front) begin
            s_next[s] = q_head[q]; s_prev[q_head[q]] = SLOT_W'(s); q_head[q] = SLOT_W'(s);
        end else begin
            s_prev[s] = q_tail[q]; s_next[q_tail[q]] = SLOT_W'(s); q_tail[q] = SLOT_W'(s);
        end
    endfunction

    function bit queue_ok(int q);
        return q < ((qiu > NUM_QUEUES) ? NUM_QUEUES : qiu);
    endfunction

    function bit has_item(int s);
        return s_valid[s];
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [QID_W-1:0] qid,
                               logic [LPA_W-1:0] lpa, logic [HANDLE_W-1:0] req,
                               logic [SLOT_W-1:0] sl);
        t_result r;
        bit qv;
        int s, e, h;
        r = '0;
        r.status = ST_DONE;
        qv = queue_ok(qid);
        if (kind == KIND_ENQ) begin
            s = -1;
            if (!qv || (lim && count >= cap)) r.status = ST_REJECT;
            else begin
                for (int i = MAX_ITEMS - 1; i >= 0; i--) if (!s_valid[i]) s = i;
                if (s < 0) r.status = ST_REJECT;
                else begin
                    e = find_addr(lpa);
                    if (e < 0) begin
                        for (int i = MAX_ITEMS - 1; i >= 0; i--) if (!a_valid[i]) e = i;
                        if (e < 0) e = 0;
                        a_valid[e] = 1; a_key[e] = lpa;
                        a_cur[e] = TAG_W'(1); a_new[e] = TAG_W'(1);
                    end else a_new[e] = a_new[e] + TAG_W'(1);
                    s_valid[s] = 1; s_locked[s] = 0; s_addr[s] = lpa;
                    s_tag[s] = a_new[e]; s_req[s] = req;
                    push(qid, s, 0);
                    count++;
                    r.slot_out = SLOT_W'(s);
                end
            end
        end else if (kind == KIND_DEQ) begin
            if (!qv) r.status = ST_REJECT;
            else if (!q_occ[qid]) r.status = ST_NONE;
            else begin
                h = q_head[qid];
                e = find_addr(s_addr[h]);
                if (s_locked[h] || e < 0 || a_cur[e] != s_tag[h]) r.status = ST_NONE;
                else begin
                    s_locked[h] = 1; r.slot_out = SLOT_W'(h); r.request_out = s_req[h];
                end
            end
        end else if (kind == KIND_REM) begin
            if (!s_valid[sl]) r.status = ST_NONE;
            else begin
                e = find_addr(s_addr[sl]);
                if (e >= 0) begin
                    if (a_new[e] == a_cur[e]) a_valid[e] = 0;
                    else a_cur[e] = a_cur[e] + TAG_W'(1);
                end
                unlink(sl);
                s_valid[sl] = 0; s_locked[sl] = 0;
                if (count > 0) count--;
            end
        end else if (kind == KIND_MOVE) begin
            if (!qv) r.status = ST_REJECT;
            else if (!s_valid[sl]) r.status = ST_NONE;
            else begin
                unlink(sl); s_locked[sl] = 0; push(qid, sl, 1);
            end
        end else if (!qv) r.status = ST_REJECT;
        r.head_ready = qv && q_occ[qid] && !s_locked[q_head[qid]];
        r.item_count_out = CNT_W'(count);
        r.full_res = lim && (count == cap);
        r.all_empty = (count == 0);
        pending.push_back(r);
    endfunction

    function void check_result(t_result got);
        t_result x;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result word %h", $realtime, got);
            errors++;
            return;
        end
        x = pending.pop_front();
        checked++;
        if (got.status !== x.status)
            $display("%0t: status exp %0d got %0d", $realtime, x.status, got.status);
        if (got.slot_out !== x.slot_out)
            $display("%0t: slot_out exp %0d got %0d", $realtime, x.slot_out, got.slot_out);
        if (got.request_out !== x.request_out)
            $display("%0t: request_out exp %h got %h", $realtime, x.request_out,
                     got.request_out);
        if (got.head_ready !== x.head_ready)
            $display("%0t: head_ready exp %b got %b", $realtime, x.head_ready,
                     got.head_ready);
        if (got.item_count_out !== x.item_count_out)
            $display("%0t: item_count exp %0d got %0d", $realtime, x.item_count_out,
                     got.item_count_out);
        if (got.full_res !== x.full_res)
            $display("%0t: full exp %b got %b", $realtime, x.full_res, got.full_res);
        if (got.all_empty !== x.all_empty)
            $display("%0t: all_empty exp %b got %b", $realtime, x.all_empty,
                     got.all_empty);
        if (got !== x) errors++;
    endfunction
endclass

module address_ordered_multi_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    aomq_in_if  req_if();
    aomq_out_if rsp_if();

    address_ordered_multi_queue i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    aomq_scoreboard board = new();
    bit quiet = 0;
    bit send_gaps = 1;
    bit sink_gaps = 1;
    int idle_cycles = 0;
    int sent = 0;
    logic [LPA_W-1:0] addr_pool[8];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side: random stall bursts, sampling at the rising edge.
    initial begin
        int gap;
        rsp_if.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (sink_gaps && !quiet && $urandom_range(0, 3) == 0) begin
                rsp_if.ready <= 1'b0;
                gap = $urandom_range(1, 3);
                repeat (gap) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            board.check_result({rsp_if.status, rsp_if.slot_out, rsp_if.request_out,
                                rsp_if.head_ready, rsp_if.item_count_out,
                                rsp_if.full_res, rsp_if.all_empty});
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("FAIL address_ordered_multi_queue");
            $finish;
        end
    end

    task automatic send_word(logic [KIND_W-1:0] kind, logic [QID_W-1:0] qid,
                             logic [LPA_W-1:0] lpa, logic [HANDLE_W-1:0] rh,
                             logic [SLOT_W-1:0] sl);
        int gap;
        if (send_gaps && !quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.kind <= kind; req_if.queue_id <= qid; req_if.lpa <= lpa;
        req_if.request_handle <= rh; req_if.slot <= sl;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        board.note_request(kind, qid, lpa, rh, sl);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({idx, 2'b00}); pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_QIU: board.qiu = value[QIU_W-1:0];
            REG_CAP: board.cap = value[CAP_W-1:0];
            default: board.lim = value[0];
        endcase
    endtask

    task automatic configure(int qiu, int cap, int lim);
        drain();
        write_reg(REG_QIU, qiu);
        write_reg(REG_CAP, cap);
        write_reg(REG_LIM, lim);
    endtask

    // Mostly held slots and known addresses so that dequeue and remove
    // find work; a few words hit empty slots or bad queues.
    task automatic random_word();
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] sl;
        logic [QID_W-1:0] qid;
        logic [LPA_W-1:0] lpa;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) kind = KIND_ENQ;
        else if (pick < 60) kind = KIND_DEQ;
        else if (pick < 82) kind = KIND_REM;
        else if (pick < 92) kind = KIND_MOVE;
        else kind = KIND_W'($urandom_range(4, 7));
        qid = ($urandom_range(0, 9) == 0) ? QID_W'($urandom) : QID_W'($urandom_range(0, 3));
        lpa = ($urandom_range(0, 4) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)];
        sl = SLOT_W'($urandom);
        if ($urandom_range(0, 9) != 0)
            for (int t = 0; t < 8 && !board.has_item(sl); t++) sl = SLOT_W'($urandom);
        send_word(kind, qid, lpa, HANDLE_W'($urandom), sl);
    endtask

    initial begin
        req_if.valid = 1'b0; req_if.kind = '0; req_if.queue_id = '0;
        req_if.lpa = '0; req_if.request_handle = '0; req_if.slot = '0;
        for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, every kind, ordering on a shared address.
        send_word(KIND_QUERY, 0, 0, 0, 0);
        send_word(KIND_DEQ, 0, 0, 0, 0);
        send_word(KIND_REM, 0, 0, 0, 0);
        send_word(KIND_MOVE, 1, 0, 0, 5);
        send_word(KIND_ENQ, 0, '1, '1, 0);
        send_word(KIND_ENQ, 1, '1, 16'h0000, '1);
        send_word(KIND_ENQ, 15, 0, 16'h5a5a, 0);
        send_word(KIND_DEQ, 1, 0, 0, 0);
        send_word(KIND_DEQ, 0, 0, 0, 0);
        send_word(KIND_DEQ, 0, 0, 0, 0);
        send_word(KIND_DEQ, 1, 0, 0, 0);
        send_word(KIND_REM, 0, 0, 0, 0);
        send_word(KIND_DEQ, 1, 0, 0, 0);
        send_word(KIND_MOVE, 1, 0, 0, 1);
        send_word(KIND_MOVE, 15, 0, 0, 1);
        send_word(KIND_MOVE, 15, 0, 0, 2);
        send_word(3'd7, 15, 0, 0, 0);
        send_word(3'd5, 3, 0, 0, 0);
        send_word(KIND_REM, 0, 0, 0, 63);
        send_word(KIND_REM, 0, 0, 0, 1);
        send_word(KIND_REM, 0, 0, 0, 2);

        configure(0, 0, 1);
        send_word(KIND_ENQ, 0, 1, 1, 0);
        send_word(KIND_QUERY, 0, 0, 0, 0);
        configure(31, 2, 1);
        repeat (4) send_word(KIND_ENQ, 2, 7, HANDLE_W'($urandom), 0);
        send_word(KIND_REM, 0, 0, 0, 0);
        send_word(KIND_REM, 0, 0, 0, 1);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: configure(16, 64, 1);
                1: configure(4, 10, 1);
                2: configure(1, 0, 0);
                3: configure(16, 64, 0);
                4: configure(7, 40, 1);
                default: configure(16, 64, 1);
            endcase
            if (phase == 5) begin
                send_gaps = 0;
                sink_gaps = 0;
            end
            for (int n = 0; n < 215; n++) begin
                random_word();
                // Hold off until everything has come back, once per phase.
                if (n == 100) drain();
            end
        end
        // Ordering on one address: repeated enqueue, remove and dequeue.
        configure(16, 64, 1);
        send_word(KIND_ENQ, 0, 32'h1234, 1, 0);
        for (int n = 0; n < 20; n++) begin
            send_word(KIND_ENQ, 0, 32'h1234, HANDLE_W'(n), 0);
            send_word(KIND_REM, 0, 0, 0, 0);
            send_word(KIND_DEQ, 0, 0, 0, 0);
        end
        drain();
        $display("Sent %0d words over several queue and capacity settings; %0d results checked.",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS address_ordered_multi_queue");
        end else begin
            $display("FAIL address_ordered_multi_queue");
        end
        $finish;
    end
endmodule
